/* design/msp_pkg.sv */
`timescale 1ns / 1ps
package msp_pkg;

    localparam int NUM_STACKS = 16;
    localparam int POOL_DEPTH = 256;

    localparam int SID_W  = 4;
    localparam int VAL_W  = 31;
    localparam int STAT_W = 2;
    localparam int STK_W  = $clog2(NUM_STACKS);
    localparam int ADDR_W = $clog2(POOL_DEPTH);
    localparam int PTR_W  = $clog2(POOL_DEPTH + 1);

    localparam logic [PTR_W-1:0] NIL_PTR = PTR_W'(POOL_DEPTH);

    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic load;
        logic exec;
    } msp_cmd_t;

    typedef struct packed {
        logic out_free;
    } msp_sts_t;

endpackage

/* design/msp_ctrl.sv */
`timescale 1ns / 1ps
module msp_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  msp_pkg::msp_sts_t sts,
    output msp_pkg::msp_cmd_t cmd
);
    import msp_pkg::*;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    logic state_reg;
    logic state_next;

    assign s_ready  = (state_reg == ST_IDLE) && sts.out_free;
    assign cmd.load = s_valid && s_ready;
    assign cmd.exec = (state_reg == ST_EXEC);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (cmd.load) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

/* design/msp_dp.sv */
`timescale 1ns / 1ps
module msp_dp (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  msp_pkg::msp_cmd_t          cmd,
    output msp_pkg::msp_sts_t          sts,
    input  logic                       s_req_type,
    input  logic [msp_pkg::SID_W-1:0]  s_stack_id,
    input  logic [msp_pkg::VAL_W-1:0]  s_push_value,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [msp_pkg::VAL_W-1:0]  m_pop_value,
    output logic [msp_pkg::STAT_W-1:0] m_status
);
    import msp_pkg::*;

    logic [PTR_W-1:0] stack_top_reg [NUM_STACKS];
    logic [PTR_W-1:0] node_link [POOL_DEPTH];
    logic [VAL_W-1:0] node_value [POOL_DEPTH];

    logic [PTR_W-1:0]  free_head_reg;
    logic [PTR_W-1:0]  free_head_next;
    logic [PTR_W-1:0]  used_cnt_reg;
    logic [PTR_W-1:0]  used_cnt_next;

    logic              req_pop_reg;
    logic              sid_ok_reg;
    logic [STK_W-1:0]  sid_reg;
    logic [VAL_W-1:0]  val_reg;
    logic [PTR_W-1:0]  top_reg;
    logic [PTR_W-1:0]  link_rd_reg;
    logic [VAL_W-1:0]  value_rd_reg;

    logic              m_valid_reg;
    logic [VAL_W-1:0]  m_pop_value_reg;
    logic [STAT_W-1:0] m_status_reg;

    logic              sid_ok_in;
    logic [STK_W-1:0]  sid_in;
    logic [PTR_W-1:0]  top_in;
    logic [PTR_W-1:0]  rd_addr;

    logic              link_we;
    logic [ADDR_W-1:0] link_wa;
    logic [PTR_W-1:0]  link_wd;
    logic              value_we;
    logic [ADDR_W-1:0] value_wa;
    logic              top_we;
    logic [PTR_W-1:0]  top_wd;
    logic [PTR_W-1:0]  slot;
    logic              slot_ok;
    logic [VAL_W-1:0]  res_value;
    logic [STAT_W-1:0] res_status;

    assign sts.out_free = !m_valid_reg || m_ready;
    assign m_valid      = m_valid_reg;
    assign m_pop_value  = m_pop_value_reg;
    assign m_status     = m_status_reg;

    // look up the stack top at accept time so the node read is issued at once
    assign sid_ok_in = (32'(s_stack_id) < NUM_STACKS);
    assign sid_in    = STK_W'(s_stack_id);
    assign top_in    = sid_ok_in ? stack_top_reg[sid_in] : NIL_PTR;
    assign rd_addr   = s_req_type ? top_in : free_head_reg;

    always_comb begin
        free_head_next = free_head_reg;
        used_cnt_next  = used_cnt_reg;
        link_we        = 1'b0;
        link_wa        = '0;
        link_wd        = '0;
        value_we       = 1'b0;
        value_wa       = '0;
        top_we         = 1'b0;
        top_wd         = NIL_PTR;
        slot           = NIL_PTR;
        slot_ok        = 1'b0;
        res_value      = '0;
        res_status     = ST_OK;
        if (req_pop_reg) begin
            if (top_reg < NIL_PTR) begin
                res_value      = value_rd_reg;
                top_we         = 1'b1;
                top_wd         = (link_rd_reg > NIL_PTR) ? NIL_PTR : link_rd_reg;
                link_we        = 1'b1;
                link_wa        = ADDR_W'(top_reg);
                link_wd        = free_head_reg;
                free_head_next = top_reg;
            end else begin
                res_status = ST_EMPTY;
            end
        end else begin
            priority if (!sid_ok_reg) begin
                res_status = ST_FULL;
            end else if (free_head_reg < NIL_PTR) begin
                slot           = free_head_reg;
                slot_ok        = 1'b1;
                free_head_next = (link_rd_reg > NIL_PTR) ? NIL_PTR : link_rd_reg;
            end else if (used_cnt_reg < NIL_PTR) begin
                slot          = used_cnt_reg;
                slot_ok       = 1'b1;
                used_cnt_next = used_cnt_reg + 1'b1;
            end else begin
                res_status = ST_FULL;
            end
            if (slot_ok) begin
                value_we = 1'b1;
                value_wa = ADDR_W'(slot);
                link_we  = 1'b1;
                link_wa  = ADDR_W'(slot);
                link_wd  = stack_top_reg[sid_reg];
                top_we   = 1'b1;
                top_wd   = slot;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            link_rd_reg <= node_link[ADDR_W'(rd_addr)];
        end
        if (cmd.exec && link_we) begin
            node_link[link_wa] <= link_wd;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            value_rd_reg <= node_value[ADDR_W'(top_in)];
        end
        if (cmd.exec && value_we) begin
            node_value[value_wa] <= val_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            req_pop_reg <= s_req_type;
            sid_ok_reg  <= sid_ok_in;
            sid_reg     <= sid_in;
            val_reg     <= s_push_value;
            top_reg     <= top_in;
        end
        if (cmd.exec) begin
            m_pop_value_reg <= res_value;
            m_status_reg    <= res_status;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_STACKS; i++) begin
                stack_top_reg[i] <= NIL_PTR;
            end
            free_head_reg <= NIL_PTR;
            used_cnt_reg  <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (cmd.exec) begin
                free_head_reg <= free_head_next;
                used_cnt_reg  <= used_cnt_next;
                if (top_we) begin
                    stack_top_reg[sid_reg] <= top_wd;
                end
            end
            if (cmd.exec) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

endmodule

/* design/multi_stack_shared_pool.sv */
// A request and its node reads are registered on transfer; the result is
//   registered in EXEC. No new request is taken until the node memory
//   read-modify-write ends (read at accept, write back in the next cycle).
// Reset (aresetn, synchronous, active low): all stacks empty, free list
//   empty, no slot used, no result pending; node memories need no clearing.
`timescale 1ns / 1ps
module multi_stack_shared_pool (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic                       s_req_type,
    input  logic [msp_pkg::SID_W-1:0]  s_stack_id,
    input  logic [msp_pkg::VAL_W-1:0]  s_push_value,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [msp_pkg::VAL_W-1:0]  m_pop_value,
    output logic [msp_pkg::STAT_W-1:0] m_status
);
    import msp_pkg::*;

    msp_cmd_t cmd;
    msp_sts_t sts;

    msp_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    msp_dp u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .sts          (sts),
        .s_req_type   (s_req_type),
        .s_stack_id   (s_stack_id),
        .s_push_value (s_push_value),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_pop_value  (m_pop_value),
        .m_status     (m_status)
    );

endmodule

/* tb/stack_pool_checker.sv */
`timescale 1ns / 1ps
module stack_pool_checker (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    input  logic                       s_ready,
    input  logic                       s_req_type,
    input  logic [msp_pkg::SID_W-1:0]  s_stack_id,
    input  logic [msp_pkg::VAL_W-1:0]  s_push_value,
    input  logic                       m_valid,
    input  logic                       m_ready,
    input  logic [msp_pkg::VAL_W-1:0]  m_pop_value,
    input  logic [msp_pkg::STAT_W-1:0] m_status,
    output int                         errors,
    output int                         pending
);
    import msp_pkg::*;

    typedef struct packed {
        logic [VAL_W-1:0]  value;
        logic [STAT_W-1:0] status;
    } stack_reply_t;

    logic [PTR_W-1:0] top_ptr   [NUM_STACKS];
    logic [PTR_W-1:0] node_link [POOL_DEPTH];
    logic [VAL_W-1:0] node_val  [POOL_DEPTH];
    logic [PTR_W-1:0] free_head;
    logic [PTR_W-1:0] used_count;
    stack_reply_t     awaited_replies [$];
    int               mismatches = 0;

    assign errors = mismatches;

    function automatic stack_reply_t serve_request(input logic is_pop,
                                                   input logic [SID_W-1:0] sid,
                                                   input logic [VAL_W-1:0] val);
        stack_reply_t     r;
        logic [PTR_W-1:0] top;
        logic [PTR_W-1:0] next;
        logic [PTR_W-1:0] slot;
        r.value  = '0;
        r.status = ST_OK;
        if (is_pop) begin
            top = (sid < NUM_STACKS) ? top_ptr[sid] : NIL_PTR;
            if (top < NIL_PTR) begin
                next = node_link[top[ADDR_W-1:0]];
                if (next > NIL_PTR)
                    next = NIL_PTR;
                r.value = node_val[top[ADDR_W-1:0]];
                top_ptr[sid] = next;
                node_link[top[ADDR_W-1:0]] = free_head;
                free_head = top;
            end else begin
                r.status = ST_EMPTY;
            end
        end else if (sid < NUM_STACKS) begin
            slot = NIL_PTR;
            if (free_head < NIL_PTR) begin
                slot = free_head;
                free_head = node_link[slot[ADDR_W-1:0]];
                if (free_head > NIL_PTR)
                    free_head = NIL_PTR;
            end else if (used_count < POOL_DEPTH) begin
                slot = used_count;
                used_count = used_count + 1'b1;
            end
            if (slot < NIL_PTR) begin
                node_val[slot[ADDR_W-1:0]]  = val;
                node_link[slot[ADDR_W-1:0]] = top_ptr[sid];
                top_ptr[sid] = slot;
            end else begin
                r.status = ST_FULL;
            end
        end else begin
            r.status = ST_FULL;
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [VAL_W-1:0] got,
                                   input logic [VAL_W-1:0] want);
        $display("%0t ns: %s: got %h, expected %h", $time, what, got, want);
        mismatches++;
    endtask

    always @(posedge aclk) begin : track
        stack_reply_t want;
        int i;
        if (!aresetn) begin
            for (i = 0; i < NUM_STACKS; i++)
                top_ptr[i] = NIL_PTR;
            free_head  = NIL_PTR;
            used_count = '0;
            awaited_replies.delete();
            pending <= 0;
        end else begin
            if (m_valid && m_ready) begin
                if (awaited_replies.size() == 0) begin
                    report_mismatch("reply transfer with none awaited", m_pop_value, '0);
                end else begin
                    want = awaited_replies.pop_front();
                    if (m_pop_value !== want.value)
                        report_mismatch("pop_value", m_pop_value, want.value);
                    if (m_status !== want.status)
                        report_mismatch("status", VAL_W'(m_status), VAL_W'(want.status));
                end
            end
            if (s_valid && s_ready)
                awaited_replies.push_back(serve_request(s_req_type, s_stack_id,
                                                        s_push_value));
            pending <= awaited_replies.size();
        end
    end

endmodule

/* tb/multi_stack_shared_pool_tb.sv */
`timescale 1ns / 1ps
module multi_stack_shared_pool_tb;
    import msp_pkg::*;

    localparam logic REQ_PUSH = 1'b0;
    localparam logic REQ_POP  = 1'b1;
    localparam int   CYCLE_LIMIT = 200000;
    localparam logic [VAL_W-1:0] VAL_MAX = '1;

    logic              aclk = 1'b0;
    logic              aresetn;
    logic              s_valid;
    logic              s_ready;
    logic              s_req_type;
    logic [SID_W-1:0]  s_stack_id;
    logic [VAL_W-1:0]  s_push_value;
    logic              m_valid;
    logic              m_ready;
    logic [VAL_W-1:0]  m_pop_value;
    logic [STAT_W-1:0] m_status;
    int                errors;
    int                pending;
    int                cycles = 0;
    bit                tx_calm = 1'b0;
    bit                rx_calm = 1'b0;

    multi_stack_shared_pool dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_req_type   (s_req_type),
        .s_stack_id   (s_stack_id),
        .s_push_value (s_push_value),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_pop_value  (m_pop_value),
        .m_status     (m_status)
    );

    stack_pool_checker checker_i (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_req_type   (s_req_type),
        .s_stack_id   (s_stack_id),
        .s_push_value (s_push_value),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_pop_value  (m_pop_value),
        .m_status     (m_status),
        .errors       (errors),
        .pending      (pending)
    );

    always #2 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        int gap;
        m_ready <= 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            gap = rx_calm ? 0 : $urandom_range(0, 6);
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
            if ($urandom_range(0, 39) == 0)
                rx_calm = !rx_calm;
        end
    end

    task automatic send_request(input logic req, input logic [SID_W-1:0] sid,
                                input logic [VAL_W-1:0] val);
        int gap;
        gap = tx_calm ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_req_type   <= req;
        s_stack_id   <= sid;
        s_push_value <= val;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if ($urandom_range(0, 39) == 0)
            tx_calm = !tx_calm;
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
    endtask

    task automatic random_requests(input int count, input int pop_pct);
        logic [SID_W-1:0] sid;
        logic [VAL_W-1:0] val;
        repeat (count) begin
            if ($urandom_range(0, 2) == 0)
                sid = SID_W'($urandom_range(0, NUM_STACKS - 1));
            else
                sid = SID_W'($urandom_range(0, 3));
            case ($urandom_range(0, 9))
                0: val = '0;
                1: val = VAL_MAX;
                default: val = VAL_W'($urandom);
            endcase
            if ($urandom_range(1, 100) <= pop_pct)
                send_request(REQ_POP, sid, VAL_W'($urandom));
            else
                send_request(REQ_PUSH, sid, val);
        end
    endtask

    initial begin
        aresetn      <= 1'b0;
        s_valid      <= 1'b0;
        s_req_type   <= REQ_PUSH;
        s_stack_id   <= '0;
        s_push_value <= '0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        send_request(REQ_POP,  4'd0,  '0);
        send_request(REQ_POP,  4'd15, VAL_MAX);
        send_request(REQ_PUSH, 4'd0,  VAL_MAX);
        send_request(REQ_PUSH, 4'd0,  '0);
        send_request(REQ_PUSH, 4'd15, 31'h5555_5555);
        send_request(REQ_PUSH, 4'd15, 31'h2AAA_AAAA);
        send_request(REQ_PUSH, 4'd5,  31'd1);
        send_request(REQ_POP,  4'd0,  '0);
        send_request(REQ_POP,  4'd0,  '0);
        send_request(REQ_POP,  4'd0,  '0);
        send_request(REQ_PUSH, 4'd10, 31'h4000_0000);
        send_request(REQ_PUSH, 4'd10, 31'd123);
        send_request(REQ_PUSH, 4'd10, 31'h3FFF_FFFF);
        send_request(REQ_POP,  4'd15, '0);
        send_request(REQ_POP,  4'd15, '0);
        send_request(REQ_POP,  4'd15, '0);
        send_request(REQ_POP,  4'd5,  '0);
        send_request(REQ_POP,  4'd10, '0);
        send_request(REQ_POP,  4'd10, '0);
        send_request(REQ_POP,  4'd10, '0);
        send_request(REQ_POP,  4'd10, '0);
        wait_drained();

        random_requests(150, 50);
        wait_drained();
        // push hard enough to exhaust the pool and hit dropped pushes
        random_requests(320, 5);
        wait_drained();
        random_requests(200, 85);
        wait_drained();
        random_requests(60, 45);
        wait_drained();

        repeat (12) @(posedge aclk);
        if (errors == 0 && pending == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

/* files.f */
design/msp_pkg.sv
design/msp_ctrl.sv
design/msp_dp.sv
design/multi_stack_shared_pool.sv
tb/stack_pool_checker.sv
tb/multi_stack_shared_pool_tb.sv
